// File: hw/rtl/lgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// shared types and constants of the life grid step core
// ----------------------------------------------------------------------------
package lgs_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_MAX_COLS = 64;

    localparam int CNT_W   = 13;
    localparam int SIZE_W  = 7;
    localparam int MODE_W  = 2;
    localparam int OP_W    = 2;
    localparam int POS_W   = 6;
    localparam int CFG_A_W = 2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 13'h1fff;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_WRAP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOUNCE = 2'd2;

    localparam logic [CFG_A_W-1:0] REG_GRID_COLS = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_GRID_ROWS = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_EDGE_MODE = 2'd2;

    localparam logic [1:0] RD_ITEM = 2'd0;
    localparam logic [1:0] RD_UP   = 2'd1;
    localparam logic [1:0] RD_MID  = 2'd2;
    localparam logic [1:0] RD_DN   = 2'd3;

    localparam logic [1:0] CAP_NONE = 2'd0;
    localparam logic [1:0] CAP_UP   = 2'd1;
    localparam logic [1:0] CAP_MID  = 2'd2;
    localparam logic [1:0] CAP_DN   = 2'd3;

    typedef struct packed {
        logic       take;
        logic [1:0] rd_sel;
        logic [1:0] cap;
        logic       item_exec;
        logic       gen_start;
        logic       cell_step;
        logic       row_wr;
        logic       row_next;
        logic       row_clr;
        logic       copy_wr;
        logic       out_load;
    } lgs_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            row_last;
        logic            col_last;
        logic            out_busy;
    } lgs_status_t;

endpackage

// File: hw/rtl/lgs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/lgs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_ctrl
// sequencer for cell access, row fetch, cell sweep and copy back
// ----------------------------------------------------------------------------
module lgs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lgs_pkg::lgs_status_t st,
    output lgs_pkg::lgs_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_ITEM_DO = 4'd2;
    localparam logic [3:0] S_LD_UP   = 4'd3;
    localparam logic [3:0] S_LD_MID  = 4'd4;
    localparam logic [3:0] S_LD_DN   = 4'd5;
    localparam logic [3:0] S_LD_WAIT = 4'd6;
    localparam logic [3:0] S_CELL    = 4'd7;
    localparam logic [3:0] S_ROW_WR  = 4'd8;
    localparam logic [3:0] S_COPY_RD = 4'd9;
    localparam logic [3:0] S_COPY_WR = 4'd10;
    localparam logic [3:0] S_FIN     = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = lgs_pkg::RD_ITEM;
        cmd.cap    = lgs_pkg::CAP_NONE;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (st.op == lgs_pkg::OP_WRITE || st.op == lgs_pkg::OP_READ)
                begin
                    state_next = S_ITEM_DO;
                end
                else if (st.op == lgs_pkg::OP_STEP)
                begin
                    cmd.gen_start = 1'b1;
                    state_next    = S_LD_UP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_ITEM_DO:
            begin
                cmd.item_exec = 1'b1;
                state_next    = S_FIN;
            end
            S_LD_UP:
            begin
                cmd.rd_sel = lgs_pkg::RD_UP;
                state_next = S_LD_MID;
            end
            S_LD_MID:
            begin
                cmd.rd_sel = lgs_pkg::RD_MID;
                cmd.cap    = lgs_pkg::CAP_UP;
                state_next = S_LD_DN;
            end
            S_LD_DN:
            begin
                cmd.rd_sel = lgs_pkg::RD_DN;
                cmd.cap    = lgs_pkg::CAP_MID;
                state_next = S_LD_WAIT;
            end
            S_LD_WAIT:
            begin
                cmd.cap    = lgs_pkg::CAP_DN;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                cmd.cell_step = 1'b1;
                if (st.col_last)
                begin
                    state_next = S_ROW_WR;
                end
            end
            S_ROW_WR:
            begin
                cmd.row_wr = 1'b1;
                if (st.row_last)
                begin
                    cmd.row_clr = 1'b1;
                    state_next  = S_COPY_RD;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                    state_next   = S_LD_UP;
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (st.row_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.row_next = 1'b1;
                    state_next   = S_COPY_RD;
                end
            end
            S_FIN:
            begin
                if (!st.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/lgs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_datapath
// grid memories, row buffers, neighbour count, counters and result register
// ----------------------------------------------------------------------------
module lgs_datapath #(
    parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [lgs_pkg::SIZE_W-1:0]   grid_cols,
    input  logic [lgs_pkg::SIZE_W-1:0]   grid_rows,
    input  logic [lgs_pkg::MODE_W-1:0]   edge_mode,
    input  logic [lgs_pkg::OP_W-1:0]     op,
    input  logic [lgs_pkg::POS_W-1:0]    row,
    input  logic [lgs_pkg::POS_W-1:0]    col,
    input  logic                         alive_in,
    input  lgs_pkg::lgs_cmd_t            cmd,
    output lgs_pkg::lgs_status_t         st,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         alive_out,
    output logic [lgs_pkg::CNT_W-1:0]    births,
    output logic [lgs_pkg::CNT_W-1:0]    deaths
);

    localparam int RIW = $clog2(MAX_ROWS);
    localparam int CIW = $clog2(MAX_COLS);
    localparam int RNW = $clog2(MAX_ROWS + 1);
    localparam int CNW = $clog2(MAX_COLS + 1);

    logic [RNW-1:0] used_rows;
    logic [CNW-1:0] used_cols;
    logic [RIW-1:0] rows_m1;
    logic [CIW-1:0] cols_m1;
    logic           wrap;
    logic           bounce;

    logic [lgs_pkg::OP_W-1:0]  op_reg;
    logic [lgs_pkg::POS_W-1:0] row_reg;
    logic [lgs_pkg::POS_W-1:0] col_reg;
    logic                      alive_reg;
    logic                      in_area;

    logic [RIW-1:0] r_reg;
    logic [CIW-1:0] c_reg;

    logic [MAX_ROWS-1:0] valid_reg;
    logic                rd_ok_reg;
    logic [RIW-1:0]      rd_addr;
    logic                rd_ok;
    logic [RIW-1:0]      up_addr;
    logic                up_ok;
    logic [RIW-1:0]      dn_addr;
    logic                dn_ok;

    logic [MAX_COLS-1:0] q_cell;
    logic [MAX_COLS-1:0] q_next;
    logic [MAX_COLS-1:0] masked;
    logic [MAX_COLS-1:0] up_reg;
    logic [MAX_COLS-1:0] mid_reg;
    logic [MAX_COLS-1:0] dn_reg;
    logic [MAX_COLS-1:0] new_reg;
    logic [MAX_COLS-1:0] item_row;

    logic                cell_we;
    logic [RIW-1:0]      cell_waddr;
    logic [MAX_COLS-1:0] cell_wdata;

    logic [CIW-1:0] cl;
    logic [CIW-1:0] cr;
    logic           lv;
    logic           rv;
    logic [3:0]     nsum;
    logic           old_c;
    logic           nxt_c;

    logic                       res_alive_reg;
    logic [lgs_pkg::CNT_W-1:0]  born_reg;
    logic [lgs_pkg::CNT_W-1:0]  died_reg;
    logic                       out_valid_reg;
    logic                       out_alive_reg;
    logic [lgs_pkg::CNT_W-1:0]  out_born_reg;
    logic [lgs_pkg::CNT_W-1:0]  out_died_reg;

    // effective grid size
    always_comb
    begin
        if (grid_rows == '0)
        begin
            used_rows = RNW'(1);
        end
        else if (int'(grid_rows) > MAX_ROWS)
        begin
            used_rows = RNW'(MAX_ROWS);
        end
        else
        begin
            used_rows = RNW'(grid_rows);
        end
        if (grid_cols == '0)
        begin
            used_cols = CNW'(1);
        end
        else if (int'(grid_cols) > MAX_COLS)
        begin
            used_cols = CNW'(MAX_COLS);
        end
        else
        begin
            used_cols = CNW'(grid_cols);
        end
    end

    assign rows_m1 = RIW'(used_rows - RNW'(1));
    assign cols_m1 = CIW'(used_cols - CNW'(1));
    assign wrap    = (edge_mode == lgs_pkg::MODE_WRAP);
    assign bounce  = (edge_mode == lgs_pkg::MODE_BOUNCE);
    assign in_area = (32'(row_reg) < 32'(used_rows)) && (32'(col_reg) < 32'(used_cols));

    // neighbour row addresses
    always_comb
    begin
        if (r_reg == '0)
        begin
            up_addr = wrap ? rows_m1 : '0;
            up_ok   = wrap || bounce;
        end
        else
        begin
            up_addr = r_reg - RIW'(1);
            up_ok   = 1'b1;
        end
        if (r_reg == rows_m1)
        begin
            dn_addr = wrap ? '0 : rows_m1;
            dn_ok   = wrap || bounce;
        end
        else
        begin
            dn_addr = r_reg + RIW'(1);
            dn_ok   = 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            lgs_pkg::RD_UP:
            begin
                rd_addr = up_addr;
                rd_ok   = up_ok;
            end
            lgs_pkg::RD_MID:
            begin
                rd_addr = r_reg;
                rd_ok   = 1'b1;
            end
            lgs_pkg::RD_DN:
            begin
                rd_addr = dn_addr;
                rd_ok   = dn_ok;
            end
            default:
            begin
                rd_addr = RIW'(row_reg);
                rd_ok   = 1'b1;
            end
        endcase
    end

    assign masked = rd_ok_reg ? q_cell : '0;

    always_comb
    begin
        item_row                 = masked;
        item_row[CIW'(col_reg)]  = alive_reg;
    end

    assign cell_we    = cmd.copy_wr || (cmd.item_exec && op_reg == lgs_pkg::OP_WRITE && in_area);
    assign cell_waddr = cmd.copy_wr ? r_reg : RIW'(row_reg);
    assign cell_wdata = cmd.copy_wr ? q_next : item_row;

    lgs_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (rd_addr),
        .rdata (q_cell)
    );

    lgs_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_next_ram (
        .clk   (clk),
        .we    (cmd.row_wr),
        .waddr (r_reg),
        .wdata (new_reg),
        .raddr (r_reg),
        .rdata (q_next)
    );

    // neighbour columns and rule
    always_comb
    begin
        if (c_reg == '0)
        begin
            cl = wrap ? cols_m1 : '0;
            lv = wrap || bounce;
        end
        else
        begin
            cl = c_reg - CIW'(1);
            lv = 1'b1;
        end
        if (c_reg == cols_m1)
        begin
            cr = wrap ? '0 : cols_m1;
            rv = wrap || bounce;
        end
        else
        begin
            cr = c_reg + CIW'(1);
            rv = 1'b1;
        end
        nsum = 4'(up_reg[cl] & lv) + 4'(up_reg[c_reg]) + 4'(up_reg[cr] & rv)
             + 4'(mid_reg[cl] & lv) + 4'(mid_reg[cr] & rv)
             + 4'(dn_reg[cl] & lv) + 4'(dn_reg[c_reg]) + 4'(dn_reg[cr] & rv);
        old_c = mid_reg[c_reg];
        nxt_c = (nsum == 4'd3) || (old_c && nsum == 4'd2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= rd_ok && valid_reg[rd_addr];
            if (cell_we)
            begin
                valid_reg[cell_waddr] <= 1'b1;
            end
            if (cmd.gen_start || cmd.row_clr)
            begin
                r_reg <= '0;
            end
            else if (cmd.row_next)
            begin
                r_reg <= r_reg + RIW'(1);
            end
            if (cmd.gen_start || (cmd.cell_step && c_reg == cols_m1))
            begin
                c_reg <= '0;
            end
            else if (cmd.cell_step)
            begin
                c_reg <= c_reg + CIW'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg        <= op;
            row_reg       <= row;
            col_reg       <= col;
            alive_reg     <= alive_in;
            res_alive_reg <= 1'b0;
            born_reg      <= '0;
            died_reg      <= '0;
        end
        if (cmd.item_exec && op_reg == lgs_pkg::OP_READ)
        begin
            res_alive_reg <= in_area && masked[CIW'(col_reg)];
        end
        case (cmd.cap)
            lgs_pkg::CAP_UP:
            begin
                up_reg <= masked;
            end
            lgs_pkg::CAP_MID:
            begin
                mid_reg <= masked;
                new_reg <= masked;
            end
            lgs_pkg::CAP_DN:
            begin
                dn_reg <= masked;
            end
            default:
            begin
            end
        endcase
        if (cmd.cell_step)
        begin
            new_reg[c_reg] <= nxt_c;
            if (!old_c && nxt_c && born_reg != lgs_pkg::COUNT_MAX)
            begin
                born_reg <= born_reg + lgs_pkg::CNT_W'(1);
            end
            if (old_c && !nxt_c && died_reg != lgs_pkg::COUNT_MAX)
            begin
                died_reg <= died_reg + lgs_pkg::CNT_W'(1);
            end
        end
        if (cmd.out_load)
        begin
            out_alive_reg <= res_alive_reg;
            out_born_reg  <= born_reg;
            out_died_reg  <= died_reg;
        end
    end

    assign st.op       = op_reg;
    assign st.row_last = (r_reg == rows_m1);
    assign st.col_last = (c_reg == cols_m1);
    assign st.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign alive_out = out_alive_reg;
    assign births    = out_born_reg;
    assign deaths    = out_died_reg;

endmodule

// File: hw/rtl/life_grid_step_with_edge_modes_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_step_with_edge_modes_core
// b3/s23 life grid with cell write, cell read and generation step
// ----------------------------------------------------------------------------
// The grid is stored one row per word in a row-wide ram, with a second ram
// holding the new generation. A generation step sweeps one cell per cycle:
// each in-use row takes three row fetches from the single read port, the cell
// sweep and the row write, then the new generation is copied back row by
// row. One item is worked on at a time; the next item is taken while the
// previous result still waits in the output register. Reset empties the
// grid at once through per-row valid flags, with no clearing pass.
// ----------------------------------------------------------------------------
module life_grid_step_with_edge_modes_core #(
    parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // op, row, col, alive_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // alive_out, births, deaths
    input  logic                          cfg_we,
    input  logic [lgs_pkg::CFG_A_W-1:0]   cfg_addr,
    input  logic [lgs_pkg::SIZE_W-1:0]    cfg_wdata
);

    logic [lgs_pkg::SIZE_W-1:0] grid_cols_reg;
    logic [lgs_pkg::SIZE_W-1:0] grid_rows_reg;
    logic [lgs_pkg::MODE_W-1:0] edge_mode_reg;

    lgs_pkg::lgs_cmd_t    cmd;
    lgs_pkg::lgs_status_t st;

    logic                      alive_out;
    logic [lgs_pkg::CNT_W-1:0] births;
    logic [lgs_pkg::CNT_W-1:0] deaths;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= 7'd64;
            grid_rows_reg <= 7'd64;
            edge_mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lgs_pkg::REG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                lgs_pkg::REG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                lgs_pkg::REG_EDGE_MODE: edge_mode_reg <= cfg_wdata[lgs_pkg::MODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    lgs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    lgs_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_cols (grid_cols_reg),
        .grid_rows (grid_rows_reg),
        .edge_mode (edge_mode_reg),
        .op        (s_tdata[1:0]),
        .row       (s_tdata[7:2]),
        .col       (s_tdata[13:8]),
        .alive_in  (s_tdata[14]),
        .cmd       (cmd),
        .st        (st),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .alive_out (alive_out),
        .births    (births),
        .deaths    (deaths)
    );

    assign m_tdata = {5'd0, deaths, births, alive_out};

    a_take_closes : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    a_rise_busy : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without an item in work");

    a_read_excl : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[26:1] == '0)
        else $error("read result carries step counts");

endmodule
